// ===== src/mfb_pkg.sv =====
// constants, codes and address helpers for the monochrome page-mode framebuffer
// no dependencies; used by the request channel interface and the top level
package mfb_pkg;

  localparam int DISP_WIDTH  = 106;
  localparam int DISP_HEIGHT = 65;
  localparam int NPAGES      = 9;
  localparam int FRAME_BYTES = DISP_WIDTH * NPAGES;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int PAGE_W      = $clog2(NPAGES);
  localparam int COL_W       = 7;

  // request function codes
  localparam logic [2:0] FN_PIXEL   = 3'd0;
  localparam logic [2:0] FN_FILL    = 3'd1;
  localparam logic [2:0] FN_MARK    = 3'd2;
  localparam logic [2:0] FN_FULL    = 3'd3;
  localparam logic [2:0] FN_INVAL   = 3'd4;
  localparam logic [2:0] FN_READ    = 3'd5;

  // pixel operation codes
  localparam logic [1:0] OP_OFF = 2'd0;
  localparam logic [1:0] OP_ON  = 2'd1;
  localparam logic [1:0] OP_INV = 2'd2;

  localparam logic [3:0] LAST_ROW = 4'd8;

  function automatic logic [ADDR_W-1:0] frame_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] p;
    p = ADDR_W'(page);
    return p * ADDR_W'(DISP_WIDTH) + ADDR_W'(col);
  endfunction

  // changed pages to transmitted rows: row r below 8 spans page r and the top of page r+1; row 8 is the top of page 0
  function automatic logic [8:0] rows_of_pages(input logic [NPAGES-1:0] changed);
    logic [8:0] rows;
    rows = '0;
    for (int r = 0; r < 8; r++) begin
      rows[r] = changed[r] | changed[r+1];
    end
    rows[8] = changed[0];
    return rows;
  endfunction

endpackage

// ===== src/mfb_req_if.sv =====
// request channel of the framebuffer: valid/ready handshake and request fields
// depends on mfb_pkg
interface mfb_req_if;
  import mfb_pkg::*;

  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [1:0]  pixel_op;
  logic [3:0]  row;
  logic [COL_W-1:0] column;

  modport source (output valid, func, x, y, pixel_op, row, column, input ready);
  modport sink   (input valid, func, x, y, pixel_op, row, column, output ready);
endinterface

// ===== src/mfb_rsp_if.sv =====
// result channel of the framebuffer: valid/ready handshake and result fields
// no dependencies
interface mfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [8:0] dirty_rows;
  logic [7:0] row_byte;

  modport source (output valid, dirty_rows, row_byte, input ready);
  modport sink   (input valid, dirty_rows, row_byte, output ready);
endinterface

// ===== src/mono_framebuffer_dirty_row_flush.sv =====
// page-mode monochrome framebuffer with shadow copy and dirty-row marking
// depends on mfb_pkg, mfb_req_if, mfb_rsp_if
// fill, invalidate and marks sweep one frame and shadow address per cycle
// throughput: one request at a time; the next is taken once the result is registered
// reset: a clearing pass zeroes the frame and sets the shadow
module mono_framebuffer_dirty_row_flush (
  input logic   clk,
  input logic   rst,
  mfb_req_if.sink   req,
  mfb_rsp_if.source rsp
);
  import mfb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIX   = 3'd1;
  localparam logic [2:0] S_RB1   = 3'd2;
  localparam logic [2:0] S_RB2   = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [1:0] K_INIT  = 2'd0;
  localparam logic [1:0] K_FILL  = 2'd1;
  localparam logic [1:0] K_INVAL = 2'd2;
  localparam logic [1:0] K_COPY  = 2'd3;

  // pixel code that changes nothing
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic [2:0] state;
  logic [1:0] kind;

  // memories
  logic [7:0] frame_mem  [FRAME_BYTES];
  logic [7:0] shadow_mem [FRAME_BYTES];
  logic [7:0] frame_rdata, shadow_rdata;
  logic [ADDR_W-1:0] frame_raddr, frame_waddr;
  logic [7:0] frame_wdata, shadow_wdata;
  logic frame_we, shadow_we;

  // request registers
  logic [2:0]  func_q;
  logic [1:0]  op_q;
  logic [3:0]  row_q;
  logic [COL_W-1:0] col_q;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0]  pix_mask;
  logic [7:0]  cur_q;
  logic [7:0]  byte_q;

  // sweep counters and delayed write stage
  logic [ADDR_W-1:0] sw_addr;
  logic [COL_W-1:0]  sw_col;
  logic [PAGE_W-1:0] sw_page;
  logic              sw_last;
  logic              d_vld;
  logic [ADDR_W-1:0] d_addr;
  logic [PAGE_W-1:0] d_page;
  logic [NPAGES-1:0] changed;

  // result register
  logic       out_valid;
  logic [8:0] out_dirty;
  logic [7:0] out_byte;

  logic accept, pix_ok, rd_ok;
  logic [ADDR_W-1:0] idle_raddr;
  logic [7:0] pix_wdata;

  assign req.ready      = (state == S_IDLE);
  assign accept         = req.valid && req.ready;
  assign rsp.valid      = out_valid;
  assign rsp.dirty_rows = out_dirty;
  assign rsp.row_byte   = out_byte;

  assign pix_ok = (req.x < 8'(DISP_WIDTH)) && (req.y < 8'(DISP_HEIGHT))
                  && (req.pixel_op != OP_SPARE);
  assign rd_ok  = ({1'b0, req.column} < 8'(DISP_WIDTH)) && (req.row <= LAST_ROW);

  assign sw_last = (sw_col == COL_W'(DISP_WIDTH - 1)) && (sw_page == PAGE_W'(NPAGES - 1));

  always_comb begin
    idle_raddr = '0;
    if (req.func == FN_READ && rd_ok) begin
      idle_raddr = frame_addr((req.row == LAST_ROW) ? '0 : PAGE_W'(req.row), req.column);
    end else if (req.func == FN_PIXEL && pix_ok) begin
      idle_raddr = frame_addr(PAGE_W'(req.y[6:3]), req.x[COL_W-1:0]);
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:  frame_raddr = idle_raddr;
      S_RB1:   frame_raddr = frame_addr(PAGE_W'(row_q + 4'd1), col_q);
      S_SWEEP: frame_raddr = sw_addr;
      default: frame_raddr = '0;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_OFF:  pix_wdata = frame_rdata & ~pix_mask;
      OP_ON:   pix_wdata = frame_rdata | pix_mask;
      OP_INV:  pix_wdata = frame_rdata ^ pix_mask;
      default: pix_wdata = frame_rdata;
    endcase
  end

  always_comb begin
    frame_we    = (state == S_PIX) || (d_vld && (kind == K_INIT || kind == K_FILL));
    frame_waddr = (state == S_PIX) ? pix_addr : d_addr;
    if (state == S_PIX) begin
      frame_wdata = pix_wdata;
    end else if (kind == K_FILL && op_q != OP_OFF) begin
      frame_wdata = 8'hFF;
    end else begin
      frame_wdata = 8'h00;
    end
    shadow_we    = d_vld && (kind != K_FILL);
    shadow_wdata = (kind == K_COPY) ? frame_rdata : 8'hFF;
  end

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_waddr] <= frame_wdata;
    end
    frame_rdata <= frame_mem[frame_raddr];
  end

  always_ff @(posedge clk) begin
    if (shadow_we) begin
      shadow_mem[d_addr] <= shadow_wdata;
    end
    shadow_rdata <= shadow_mem[sw_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= req.func;
      op_q     <= req.pixel_op;
      row_q    <= req.row;
      col_q    <= req.column;
      pix_addr <= idle_raddr;
      pix_mask <= 8'h80 >> req.y[2:0];
      byte_q   <= 8'h00;
    end else if (state == S_RB1) begin
      cur_q <= frame_rdata;
      if (row_q == LAST_ROW) begin
        byte_q <= frame_rdata & 8'h80;
      end
    end else if (state == S_RB2) begin
      byte_q <= {cur_q[6:0], frame_rdata[7]};
    end
    d_addr <= sw_addr;
    d_page <= sw_page;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      kind      <= K_INIT;
      sw_addr   <= '0;
      sw_col    <= '0;
      sw_page   <= '0;
      d_vld     <= 1'b0;
      changed   <= '0;
      out_valid <= 1'b0;
      out_dirty <= '0;
      out_byte  <= '0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      // compare stage of a copy sweep (mark or full)
      if (d_vld && kind == K_COPY && frame_rdata != shadow_rdata) begin
        changed[d_page] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            changed <= '0;
            sw_addr <= '0;
            sw_col  <= '0;
            sw_page <= '0;
            case (req.func)
              FN_PIXEL: state <= pix_ok ? S_PIX : S_DONE;
              FN_FILL: begin
                kind  <= K_FILL;
                state <= S_SWEEP;
              end
              FN_MARK, FN_FULL: begin
                kind  <= K_COPY;
                state <= S_SWEEP;
              end
              FN_INVAL: begin
                kind  <= K_INVAL;
                state <= S_SWEEP;
              end
              FN_READ: state <= rd_ok ? S_RB1 : S_DONE;
              default: state <= S_DONE;
            endcase
          end
        end
        S_PIX: state <= S_DONE;
        S_RB1: state <= (row_q == LAST_ROW) ? S_DONE : S_RB2;
        S_RB2: state <= S_DONE;
        S_SWEEP: begin
          d_vld <= 1'b1;
          if (sw_last) begin
            sw_addr <= '0;
            sw_col  <= '0;
            sw_page <= '0;
            state   <= S_DRAIN;
          end else begin
            sw_addr <= sw_addr + ADDR_W'(1);
            if (sw_col == COL_W'(DISP_WIDTH - 1)) begin
              sw_col  <= '0;
              sw_page <= sw_page + PAGE_W'(1);
            end else begin
              sw_col <= sw_col + COL_W'(1);
            end
          end
        end
        S_DRAIN: begin
          d_vld <= 1'b0;
          state <= (kind == K_INIT) ? S_IDLE : S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_byte  <= (func_q == FN_READ) ? byte_q : 8'h00;
            if (func_q == FN_FULL) begin
              out_dirty <= 9'h1FF;
            end else if (func_q == FN_MARK) begin
              out_dirty <= rows_of_pages(changed);
            end else begin
              out_dirty <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !d_vld && !frame_we && !shadow_we)
    else $error("memory write pending while idle");

  a_sweep_addr: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |-> sw_addr == frame_addr(sw_page, sw_col))
    else $error("sweep address out of step with page and column");

  a_drain_follows: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> d_vld && $past(state) == S_SWEEP)
    else $error("drain without a sweep in flight");

  a_rb2_order: assert property (@(posedge clk) disable iff (rst)
    state == S_RB2 |-> $past(state) == S_RB1 && row_q != LAST_ROW)
    else $error("second row read out of order");

  a_pix_order: assert property (@(posedge clk) disable iff (rst)
    state == S_PIX |-> $past(state) == S_IDLE && op_q != OP_SPARE)
    else $error("pixel write without a fresh request");

endmodule
